// ----- src/skt_pkg.sv -----
// Package for the sorted key table: record and probe types, request and status codes.
// Has no dependencies. The cell, controller and top-level modules use it.
package skt_pkg;

  // Request codes carried on req_type.
  localparam logic ReqLookup = 1'b0;
  localparam logic ReqInsert = 1'b1;

  // Result status codes.
  localparam logic [2:0] StFound     = 3'd0;
  localparam logic [2:0] StNotFound  = 3'd1;
  localparam logic [2:0] StInserted  = 3'd2;
  localparam logic [2:0] StDuplicate = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ClassW = 8;
  localparam int unsigned OnHandW = 20;
  localparam int unsigned CostW  = 24;
  localparam int unsigned ValueW = 44;
  localparam int unsigned SlotW  = 6;

  // Payload of one record, without its key.
  typedef struct packed {
    logic [ClassW-1:0]  cls;
    logic [OnHandW-1:0] on_hand;
    logic [CostW-1:0]   cost;
  } data_t;

  // One table record as held in a cell.
  typedef struct packed {
    logic [KeyW-1:0] key;
    data_t           data;
  } rec_t;

  // Search probe that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic  valid;
    logic  hit;
    data_t data;
  } probe_t;

endpackage

// ----- src/skt_cell.sv -----
// One cell of the sorted table: holds one record, checks the passing search probe,
// and takes its lower neighbor's record when an insert opens a gap. Uses skt_pkg.
module skt_cell #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned IDX         = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [skt_pkg::KeyW-1:0]         key_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] count_i,
  input  skt_pkg::probe_t                  probe_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] pos_i,
  output skt_pkg::probe_t                  probe_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] pos_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] wr_pos_i,
  input  skt_pkg::rec_t                    new_rec_i,
  input  skt_pkg::rec_t                    prev_rec_i,
  output skt_pkg::rec_t                    rec_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH+1);
  localparam logic [CW-1:0] IdxC  = CW'(IDX);
  localparam logic [CW-1:0] IdxP1 = CW'(IDX + 1);

  skt_pkg::rec_t   rec_q;
  skt_pkg::probe_t probe_d, probe_q;
  logic [CW-1:0]   pos_d, pos_q;
  logic            occ, lt, eq;

  // Compare the held key against the query; only slots below the count take part.
  assign occ = IdxC < count_i;
  assign lt  = occ && (rec_q.key < key_i);
  assign eq  = occ && (rec_q.key == key_i);

  // Lower-bound position and hit data accumulate as the probe passes.
  always_comb begin
    probe_d       = probe_i;
    probe_d.hit   = probe_i.hit | eq;
    probe_d.data  = eq ? rec_q.data : probe_i.data;
    pos_d         = lt ? IdxP1 : (eq ? IdxC : pos_i);
  end

  // Probe stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      pos_q   <= '0;
    end else begin
      probe_q <= probe_d;
      pos_q   <= pos_d;
    end
  end

  // Record storage: take the new record at the insert slot, or shift up from below.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (IdxC == wr_pos_i) begin
        rec_q <= new_rec_i;
      end else if ((IdxC > wr_pos_i) && (IdxC <= count_i)) begin
        rec_q <= prev_rec_i;
      end
    end
  end

  assign probe_o = probe_q;
  assign pos_o   = pos_q;
  assign rec_o   = rec_q;

endmodule

// ----- src/skt_ctrl.sv -----
// Controller of the sorted table: takes requests, launches the search probe,
// decides the status, computes the stock value and holds the result. Uses skt_pkg.
module skt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [skt_pkg::KeyW-1:0]         part_key_i,
  input  logic [skt_pkg::ClassW-1:0]       class_code_i,
  input  logic [skt_pkg::OnHandW-1:0]      on_hand_in_i,
  input  logic [skt_pkg::CostW-1:0]        unit_cost_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [skt_pkg::SlotW-1:0]        slot_index_o,
  output logic [skt_pkg::ClassW-1:0]       class_out_o,
  output logic [skt_pkg::OnHandW-1:0]      on_hand_out_o,
  output logic [skt_pkg::CostW-1:0]        unit_cost_out_o,
  output logic [skt_pkg::ValueW-1:0]       stock_value_o,
  output logic [skt_pkg::KeyW-1:0]         key_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] count_o,
  output skt_pkg::probe_t                  launch_o,
  input  skt_pkg::probe_t                  last_probe_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] last_pos_i,
  output logic                             wr_en_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] wr_pos_o,
  output skt_pkg::rec_t                    new_rec_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH+1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    CALC,
    RESULT
  } state_e;

  state_e                       state_q;
  logic                         req_q;
  skt_pkg::rec_t                rec_q;
  logic [CW-1:0]                count_q;
  logic                         launch_q;
  logic                         hit_q;
  logic [CW-1:0]                pos_q;
  skt_pkg::data_t               data_q;
  logic [skt_pkg::ValueW-1:0]   prod_q;
  logic [2:0]                   res_status_q;
  logic                         ins_ok;
  logic                         in_fire;
  logic                         res_load;

  logic                         out_valid_q;
  logic [2:0]                   status_q;
  logic [skt_pkg::SlotW-1:0]    slot_q;
  skt_pkg::data_t               out_data_q;
  logic [skt_pkg::ValueW-1:0]   value_q;

  assign in_stall_o = (state_q != IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ins_ok     = (req_q == skt_pkg::ReqInsert) && !hit_q && (count_q != DepthC);
  // The result register takes a new result once it is empty or being drained.
  assign res_load   = (state_q == RESULT) && (!out_valid_q || !out_stall_i);

  // Sequencer, count, stock value multiply and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      count_q      <= '0;
      launch_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      req_q        <= skt_pkg::ReqLookup;
      rec_q        <= '0;
      hit_q        <= 1'b0;
      pos_q        <= '0;
      data_q       <= '0;
      prod_q       <= '0;
      res_status_q <= skt_pkg::StNotFound;
      status_q     <= skt_pkg::StNotFound;
      slot_q       <= '0;
      out_data_q   <= '0;
      value_q      <= '0;
    end else begin
      launch_q <= in_fire;
      if (out_valid_q && !out_stall_i && !res_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_fire) begin
            req_q             <= req_type_i;
            rec_q.key         <= part_key_i;
            rec_q.data.cls    <= class_code_i;
            rec_q.data.on_hand <= on_hand_in_i;
            rec_q.data.cost   <= unit_cost_in_i;
            state_q           <= SEARCH;
          end
        end
        SEARCH: begin
          if (last_probe_i.valid) begin
            hit_q   <= last_probe_i.hit;
            pos_q   <= last_pos_i;
            data_q  <= last_probe_i.data;
            state_q <= CALC;
          end
        end
        CALC: begin
          // Status decision; the cells shift in this same cycle on a good insert.
          if (req_q == skt_pkg::ReqLookup) begin
            res_status_q <= hit_q ? skt_pkg::StFound : skt_pkg::StNotFound;
          end else if (hit_q) begin
            res_status_q <= skt_pkg::StDuplicate;
          end else if (count_q == DepthC) begin
            res_status_q <= skt_pkg::StFull;
          end else begin
            res_status_q <= skt_pkg::StInserted;
          end
          if (ins_ok) begin
            count_q <= count_q + CW'(1);
          end
          if ((req_q == skt_pkg::ReqLookup) && hit_q) begin
            prod_q <= skt_pkg::ValueW'(data_q.on_hand) * skt_pkg::ValueW'(data_q.cost);
          end else begin
            prod_q <= '0;
            data_q <= '0;
          end
          state_q <= RESULT;
        end
        RESULT: begin
          if (res_load) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            if ((res_status_q == skt_pkg::StNotFound) || (res_status_q == skt_pkg::StFull)) begin
              slot_q <= '0;
            end else begin
              slot_q <= skt_pkg::SlotW'(pos_q);
            end
            out_data_q <= data_q;
            value_q    <= prod_q;
            state_q    <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  // Probe launched into the first cell.
  always_comb begin
    launch_o       = '0;
    launch_o.valid = launch_q;
  end

  assign key_o     = rec_q.key;
  assign count_o   = count_q;
  assign new_rec_o = rec_q;
  assign wr_en_o   = (state_q == CALC) && ins_ok;
  assign wr_pos_o  = pos_q;

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = slot_q;
  assign class_out_o     = out_data_q.cls;
  assign on_hand_out_o   = out_data_q.on_hand;
  assign unit_cost_out_o = out_data_q.cost;
  assign stock_value_o   = value_q;

endmodule

// ----- src/sorted_key_table_lookup_insert_top.sv -----
// Top level of the sorted key table: the controller and a chain of TABLE_DEPTH cells.
// Depends on skt_pkg, skt_cell and skt_ctrl.
//
// The table keeps up to TABLE_DEPTH part records in ascending order of their 64-bit key,
// one record per cell. A lookup returns the matching record and its stock value (on-hand
// count times unit cost, in cents); an insert places a new record at its sorted slot and
// reports a duplicate key or a full table without changing anything. The block works on
// one transaction at a time: a search probe walks the cell chain one cell per clock, and
// the next transaction can be accepted the cycle after the result is loaded, even while
// it still waits downstream. An insert shifts all larger records up by one slot at once.
// Table contents are undefined after reset; only the entry count is cleared.
module sorted_key_table_lookup_insert_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [skt_pkg::KeyW-1:0]      part_key_i,
  input  logic [skt_pkg::ClassW-1:0]    class_code_i,
  input  logic [skt_pkg::OnHandW-1:0]   on_hand_in_i,
  input  logic [skt_pkg::CostW-1:0]     unit_cost_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [skt_pkg::SlotW-1:0]     slot_index_o,
  output logic [skt_pkg::ClassW-1:0]    class_out_o,
  output logic [skt_pkg::OnHandW-1:0]   on_hand_out_o,
  output logic [skt_pkg::CostW-1:0]     unit_cost_out_o,
  output logic [skt_pkg::ValueW-1:0]    stock_value_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH+1);

  logic [skt_pkg::KeyW-1:0] key;
  logic [CW-1:0]            count;
  logic                     wr_en;
  logic [CW-1:0]            wr_pos;
  skt_pkg::rec_t            new_rec;
  skt_pkg::probe_t          probe [TABLE_DEPTH+1];
  logic [CW-1:0]            pos   [TABLE_DEPTH+1];
  skt_pkg::rec_t            rec   [TABLE_DEPTH+1];

  // Sequencer and result register.
  skt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .part_key_i     (part_key_i),
    .class_code_i   (class_code_i),
    .on_hand_in_i   (on_hand_in_i),
    .unit_cost_in_i (unit_cost_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .class_out_o    (class_out_o),
    .on_hand_out_o  (on_hand_out_o),
    .unit_cost_out_o(unit_cost_out_o),
    .stock_value_o  (stock_value_o),
    .key_o          (key),
    .count_o        (count),
    .launch_o       (probe[0]),
    .last_probe_i   (probe[TABLE_DEPTH]),
    .last_pos_i     (pos[TABLE_DEPTH]),
    .wr_en_o        (wr_en),
    .wr_pos_o       (wr_pos),
    .new_rec_o      (new_rec)
  );

  // The first cell never shifts in from below; its neighbor input is the new record.
  assign pos[0] = '0;
  assign rec[0] = new_rec;

  // Chain of record cells; cell i reads link i and drives link i+1.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    skt_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (key),
      .count_i   (count),
      .probe_i   (probe[i]),
      .pos_i     (pos[i]),
      .probe_o   (probe[i+1]),
      .pos_o     (pos[i+1]),
      .wr_en_i   (wr_en),
      .wr_pos_i  (wr_pos),
      .new_rec_i (new_rec),
      .prev_rec_i(rec[i]),
      .rec_o     (rec[i+1])
    );
  end

endmodule
